[sv/thp_pkg.sv]
// Package for the timing histogram percentile block.
// Holds command codes, transaction struct types and shared constants.
package thp_pkg;

   localparam int SAMPLE_W = 24;
   localparam int VALUE_W  = 23;
   localparam int SUM_W    = 56;
   localparam int FRAC_W   = 17;
   localparam int WIDTH_W  = 16;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd100;
   localparam logic [FRAC_W-1:0]  FRAC_ONE    = 17'd65536;
   localparam logic [VALUE_W-1:0] EDGE_MAX    = 23'h7FFFFF;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]               command;
      logic signed [SAMPLE_W-1:0] sample;
      logic [FRAC_W-1:0]        fraction;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] percentile_edge;
      logic [VALUE_W-1:0] minimum;
      logic [VALUE_W-1:0] maximum;
      logic [31:0]        sample_count;
      logic [SUM_W-1:0]   sample_sum;
      logic               accepted;
   } rsp_type;

   // Classified transaction handed from front to back
   typedef struct packed {
      logic [1:0]         command;
      logic               valid_sample;
      logic [VALUE_W-1:0] value;
      logic [FRAC_W-1:0]  fraction;
   } work_type;

endpackage

[sv/thp_front.sv]
// Front end of the timing histogram: accepts and classifies requests.
// Depends on thp_pkg; feeds the work queue.
module thp_front import thp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   output logic     req_full,
   input  req_type  req_data,
   output logic     work_valid,
   input  logic     work_ready,
   output work_type work_data
);

   logic     valid_ff, valid_in;
   work_type data_ff, data_in;

   assign req_full   = valid_ff && !work_ready;
   assign work_valid = valid_ff;
   assign work_data  = data_ff;

   // Classify command, clamp fraction, check sign
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (work_ready) valid_in = 1'b0;
      if (req_push && !req_full) begin
         valid_in              = 1'b1;
         data_in.command       = req_data.command;
         data_in.valid_sample  = !req_data.sample[SAMPLE_W-1];
         data_in.value         = req_data.sample[VALUE_W-1:0];
         data_in.fraction      = (req_data.fraction > FRAC_ONE) ? FRAC_ONE
                                                                : req_data.fraction;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      data_ff <= data_in;
   end

endmodule

[sv/thp_queue.sv]
// Short work queue between front and back of the histogram.
// Depends on thp_pkg for the work transaction type.
module thp_queue import thp_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   work_type        slot_ff [DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;
   logic            do_wr, do_rd;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = slot_ff[rd_ff];
   assign do_wr     = in_valid && in_ready;
   assign do_rd     = out_valid && out_ready;

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_wr) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (do_rd) rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(do_wr) - (AW+1)'(do_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wr_ff] <= in_data;
   end

endmodule

[sv/thp_back.sv]
// Back end of the timing histogram: bin memory, divider, percentile walk.
// Depends on thp_pkg; takes work from the queue and fills a result register.
module thp_back import thp_pkg::*; #(
   parameter int NUM_BINS   = 128,
   parameter int COUNT_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [WIDTH_W-1:0] csr_wdata,
   input  logic               work_valid,
   output logic               work_ready,
   input  work_type           work_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output rsp_type            rsp_data
);

   localparam int BW   = $clog2(NUM_BINS);
   localparam int RUNW = COUNT_BITS + BW;
   localparam int TW   = COUNT_BITS + FRAC_W;
   localparam int EW   = (WIDTH_W + BW > VALUE_W) ? (WIDTH_W + BW) : VALUE_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [SUM_W-1:0]      SUM_MAX = '1;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b00000001,
      ST_IDLE  = 8'b00000010,
      ST_DIV   = 8'b00000100,
      ST_RD    = 8'b00001000,
      ST_WAIT  = 8'b00010000,
      ST_WR    = 8'b00100000,
      ST_WALK  = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   state_type state_ff;
   logic [COUNT_BITS-1:0] mem [NUM_BINS];
   logic [COUNT_BITS-1:0] rdata_ff;
   logic [BW-1:0]         addr_ff;
   logic                  first_ff;
   logic                  boot_ff;

   logic [WIDTH_W-1:0]    width_ff;
   logic [COUNT_BITS-1:0] total_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [VALUE_W-1:0]    min_ff, max_ff;
   work_type              job_ff;

   // Restoring divider state
   logic [VALUE_W-1:0]    quo_ff;
   logic [WIDTH_W:0]      rem_ff;
   logic [4:0]            step_ff;

   // Walk state
   logic [RUNW-1:0]       run_ff;
   logic [TW-1:0]         target_ff;
   logic [EW-1:0]         edge_ff;
   logic                  found_ff;

   rsp_type               out_ff;
   logic                  full_ff;

   logic [WIDTH_W-1:0]    eff_w;
   logic [WIDTH_W:0]      rem_sh;
   logic [RUNW-1:0]       run_nx;
   logic [EW-1:0]         edge_nx;
   logic [BW-1:0]         bin_idx;
   logic [SUM_W-1:0]      sum_add;
   logic                  walk_hit;
   logic                  out_load;

   assign eff_w      = (width_ff == '0) ? WIDTH_W'(1) : width_ff;
   assign rem_sh     = {rem_ff[WIDTH_W-1:0], job_ff.value[VALUE_W-1-step_ff]};
   assign run_nx     = run_ff + RUNW'(rdata_ff);
   assign edge_nx    = edge_ff + EW'(eff_w);
   assign walk_hit   = ({run_nx, 16'h0000} >= (RUNW+16)'(target_ff))
                       || (run_nx == RUNW'(total_ff));
   assign bin_idx    = (quo_ff > VALUE_W'(NUM_BINS-1)) ? BW'(NUM_BINS-1)
                                                      : quo_ff[BW-1:0];
   assign sum_add    = sum_ff + SUM_W'(job_ff.value);
   assign out_load   = (state_ff == ST_OUT) && (!full_ff || rsp_pop);
   assign work_ready = (state_ff == ST_IDLE);
   assign rsp_empty  = !full_ff;
   assign rsp_data   = out_ff;

   // Bin memory: registered read, single write port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[addr_ff];
      if (state_ff == ST_CLEAR)
         mem[addr_ff] <= '0;
      else if (state_ff == ST_WR && rdata_ff != CNT_MAX)
         mem[addr_ff] <= rdata_ff + 1'b1;
   end

   // Sequence each transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         boot_ff  <= 1'b1;
         width_ff <= WIDTH_RESET;
         total_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
      end else begin
         if (csr_write) width_ff <= csr_wdata;
         case (state_ff)
            ST_CLEAR: begin
               if (addr_ff == BW'(NUM_BINS-1)) begin
                  addr_ff  <= '0;
                  boot_ff  <= 1'b0;
                  state_ff <= boot_ff ? ST_IDLE : ST_OUT;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (work_valid) begin
                  job_ff   <= work_data;
                  quo_ff   <= '0;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  run_ff   <= '0;
                  edge_ff  <= '0;
                  found_ff <= 1'b0;
                  addr_ff  <= '0;
                  target_ff <= TW'(total_ff) * TW'(work_data.fraction);
                  case (work_data.command)
                     CMD_CLEAR: begin
                        total_ff <= '0;
                        sum_ff   <= '0;
                        min_ff   <= '0;
                        max_ff   <= '0;
                        state_ff <= ST_CLEAR;
                     end
                     CMD_ADD:   state_ff <= work_data.valid_sample ? ST_DIV : ST_OUT;
                     CMD_QUERY: state_ff <= ST_RD;
                     default:   state_ff <= ST_OUT;
                  endcase
               end
            end
            ST_DIV: begin
               if (rem_sh >= {1'b0, eff_w}) begin
                  rem_ff <= rem_sh - {1'b0, eff_w};
                  quo_ff <= {quo_ff[VALUE_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[VALUE_W-2:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == 5'(VALUE_W-1)) state_ff <= ST_RD;
            end
            ST_RD: begin
               if (job_ff.command == CMD_ADD) addr_ff <= bin_idx;
               state_ff <= (job_ff.command == CMD_ADD) ? ST_WAIT : ST_WALK;
            end
            ST_WAIT: begin
               // bin address settled; its count arrives in rdata at this edge
               state_ff <= ST_WR;
            end
            ST_WR: begin
               // rdata holds the count of the addressed bin
               if (total_ff == '0) begin
                  min_ff <= job_ff.value;
                  max_ff <= job_ff.value;
               end else begin
                  if (job_ff.value < min_ff) min_ff <= job_ff.value;
                  if (job_ff.value > max_ff) max_ff <= job_ff.value;
               end
               if (total_ff != CNT_MAX) total_ff <= total_ff + 1'b1;
               sum_ff   <= (sum_add < sum_ff) ? SUM_MAX : sum_add;
               state_ff <= ST_OUT;
            end
            ST_WALK: begin
               // rdata holds bin addr-1 after first cycle; first_ff marks priming
               if (!first_ff) begin
                  run_ff  <= run_nx;
                  edge_ff <= edge_nx;
                  if (walk_hit) begin
                     found_ff <= 1'b1;
                     state_ff <= ST_OUT;
                  end else if (addr_ff == BW'(NUM_BINS)) begin
                     state_ff <= ST_OUT;
                  end
               end
               addr_ff <= addr_ff + 1'b1;
            end
            ST_OUT: begin
               if (out_load) begin
                  out_ff.percentile_edge <= (job_ff.command == CMD_QUERY && found_ff)
                     ? ((edge_ff > EW'(EDGE_MAX)) ? EDGE_MAX
                                                  : edge_ff[VALUE_W-1:0])
                     : '0;
                  out_ff.minimum      <= min_ff;
                  out_ff.maximum      <= max_ff;
                  out_ff.sample_count <= 32'(total_ff);
                  out_ff.sample_sum   <= sum_ff;
                  out_ff.accepted     <= job_ff.command == CMD_ADD && job_ff.valid_sample;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Hold the result register full until popped
   always_ff @(posedge clock) begin
      if (reset)         full_ff <= 1'b0;
      else if (out_load) full_ff <= 1'b1;
      else if (rsp_pop)  full_ff <= 1'b0;
   end

   // Track the priming cycle of the memory read pipeline
   always_ff @(posedge clock) begin
      if (reset) first_ff <= 1'b1;
      else if (state_ff == ST_IDLE) first_ff <= 1'b1;
      else if (state_ff == ST_WALK) first_ff <= 1'b0;
   end

endmodule

[sv/timing_histogram_percentile_core.sv]
// Timing histogram percentile block: request queue in, result queue out.
// Clock: clock, synchronous active-high reset.
// Channels: req_push/req_full take one command transaction (clear, add, query).
// rsp_empty/rsp_pop return one result transaction per command, in order.
// csr_write/csr_wdata set the bin width; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// An add runs the restoring divider for sample/bin_width, then a
// read-modify-write of the bin memory; a query walks the bins, up to NUM_BINS;
// a clear sweeps the bin memory.
// The back end takes one transaction at a time: it takes no new transaction
// until the result of the last one is loaded into the result register.
// Front and back are decoupled by a short queue, so requests are taken while
// the back end works; a stalled result register holds its value until popped,
// and while the queue is full and the front holds a request, req_full is high.
// Reset clears count, sum and min/max and runs a clearing pass over the bin
// memory during which no request leaves the queue.
module timing_histogram_percentile_core import thp_pkg::*; #(
   parameter int NUM_BINS   = 128,
   parameter int COUNT_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  req_type            req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output rsp_type            rsp_data,
   input  logic               csr_write,
   input  logic [WIDTH_W-1:0] csr_wdata
);

   logic     f_valid, f_ready, b_valid, b_ready;
   work_type f_data, b_data;

   thp_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .work_valid(f_valid), .work_ready(f_ready), .work_data(f_data)
   );

   thp_queue #(.DEPTH(2)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   thp_back #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock, .reset, .csr_write, .csr_wdata,
      .work_valid(b_valid), .work_ready(b_ready), .work_data(b_data),
      .rsp_empty, .rsp_pop, .rsp_data
   );

endmodule

[dv/timing_histogram_percentile_core_tb.sv]
// Testbench for timing_histogram_percentile_core: drives command transactions
// through the request queue and checks each result against a local predictor.
// Depends on thp_pkg for the command codes and transaction struct types.
`timescale 1ns / 1ps

module timing_histogram_percentile_core_tb;
   import thp_pkg::*;

   localparam int NBINS = 128;
   localparam longint unsigned CNT_LIMIT = 64'hFFFF_FFFF;
   localparam longint unsigned SUM_LIMIT = (64'd1 << 56) - 1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   req_type            req_data = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   rsp_type            rsp_data;
   logic               csr_write = 1'b0;
   logic [WIDTH_W-1:0] csr_wdata = '0;

   timing_histogram_percentile_core dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state
   longint unsigned hist_bins [NBINS];
   longint unsigned hist_total, hist_sum, hist_min, hist_max;
   longint unsigned width_reg;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int  fail_count = 0;
   bit  idle_on = 1'b1;
   bit  hold_send = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;

   // Full as seen at the last rising edge, for the driver
   logic req_full_s = 1'b0;

   function automatic void queue_req(req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic void clear_histogram();
      foreach (hist_bins[i]) hist_bins[i] = 0;
      hist_total = 0; hist_sum = 0; hist_min = 0; hist_max = 0;
   endfunction

   function automatic rsp_type predict_result(req_type r);
      rsp_type res;
      longint unsigned w, v, idx, frac, target, run, edge_val;
      w = (width_reg == 0) ? 1 : width_reg;
      res = '0;
      case (cmd_type'(r.command))
         CMD_CLEAR: clear_histogram();
         CMD_ADD: begin
            if (!r.sample[SAMPLE_W-1]) begin
               v = r.sample[VALUE_W-1:0];
               if (hist_total == 0) begin
                  hist_min = v; hist_max = v;
               end else begin
                  if (v < hist_min) hist_min = v;
                  if (v > hist_max) hist_max = v;
               end
               idx = v / w;
               if (idx > NBINS - 1) idx = NBINS - 1;
               if (hist_bins[idx] < CNT_LIMIT) hist_bins[idx]++;
               if (hist_total < CNT_LIMIT) hist_total++;
               hist_sum = (SUM_LIMIT - hist_sum < v) ? SUM_LIMIT : hist_sum + v;
               res.accepted = 1'b1;
            end
         end
         CMD_QUERY: begin
            frac = r.fraction;
            if (frac > FRAC_ONE) frac = FRAC_ONE;
            target = hist_total * frac;
            run = 0;
            for (int i = 0; i < NBINS; i++) begin
               run += hist_bins[i];
               if ((run << 16) >= target || run == hist_total) begin
                  edge_val = w * (i + 1);
                  res.percentile_edge = VALUE_W'((edge_val > EDGE_MAX) ? EDGE_MAX
                                                                       : edge_val);
                  break;
               end
            end
         end
         default: ;
      endcase
      res.minimum      = VALUE_W'(hist_min);
      res.maximum      = VALUE_W'(hist_max);
      res.sample_count = 32'(hist_total);
      res.sample_sum   = SUM_W'(hist_sum);
      return res;
   endfunction

   // Drive request transactions at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_push && req_full_s)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 5);
               req_push <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_send) begin
               req_data <= pending_reqs.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Sample full and predict each accepted request transaction
   always @(posedge clock) begin
      req_full_s <= req_full;
      if (!reset && req_push && !req_full)
         expected_rsps.insert(expected_rsps.size(), predict_result(req_data));
   end

   // Pop results with random stalls
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 5);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Check each accepted result transaction
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result transaction");
            fail_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.percentile_edge !== exp_rsp.percentile_edge) begin
               $error("percentile_edge exp %0d got %0d",
                      exp_rsp.percentile_edge, rsp_data.percentile_edge);
               fail_count++;
            end
            if (rsp_data.minimum !== exp_rsp.minimum) begin
               $error("minimum exp %0d got %0d", exp_rsp.minimum, rsp_data.minimum);
               fail_count++;
            end
            if (rsp_data.maximum !== exp_rsp.maximum) begin
               $error("maximum exp %0d got %0d", exp_rsp.maximum, rsp_data.maximum);
               fail_count++;
            end
            if (rsp_data.sample_count !== exp_rsp.sample_count) begin
               $error("sample_count exp %0d got %0d",
                      exp_rsp.sample_count, rsp_data.sample_count);
               fail_count++;
            end
            if (rsp_data.sample_sum !== exp_rsp.sample_sum) begin
               $error("sample_sum exp %0d got %0d",
                      exp_rsp.sample_sum, rsp_data.sample_sum);
               fail_count++;
            end
            if (rsp_data.accepted !== exp_rsp.accepted) begin
               $error("accepted exp %0d got %0d", exp_rsp.accepted, rsp_data.accepted);
               fail_count++;
            end
         end
      end
   end

   function automatic req_type make_req(cmd_type c, int s, int f);
      req_type r;
      r.command  = c;
      r.sample   = SAMPLE_W'(s);
      r.fraction = FRAC_W'(f);
      return r;
   endfunction

   // Mostly adds, most with values up to an eighth past bin width times NBINS, plus queries
   function automatic req_type random_req(int unsigned w);
      int unsigned pick;
      int unsigned span;
      req_type r;
      pick = $urandom_range(0, 99);
      span = (w == 0 ? 1 : w) * NBINS;
      r = '0;
      r.fraction = FRAC_W'($urandom_range(0, 131071));
      if ($urandom_range(0, 3) == 0) r.fraction = FRAC_W'($urandom_range(0, 65536));
      r.sample = SAMPLE_W'($urandom);
      if (pick < 2) r.command = CMD_CLEAR;
      else if (pick < 4) r.command = CMD_NONE;
      else if (pick < 60) begin
         r.command = CMD_ADD;
         if ($urandom_range(0, 4) != 0)
            r.sample = SAMPLE_W'($urandom_range(0, (span > 8388607) ? 8388607
                                                                   : span + span / 8));
      end else r.command = CMD_QUERY;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_push || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (NBINS + 40) @(posedge clock);
   endtask

   task automatic write_width(logic [WIDTH_W-1:0] w);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= w;
      @(negedge clock);
      csr_write <= 1'b0;
      width_reg = w;
   endtask

   initial begin
      logic [WIDTH_W-1:0] widths [6];
      widths = '{16'd0, 16'd1, 16'd65535, 16'd7, 16'd100, 16'd3000};
      clear_histogram();
      width_reg = WIDTH_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: default width, extremes and special cases
      queue_req(make_req(CMD_QUERY, 0, 32768));
      queue_req(make_req(CMD_ADD, -1, 0));
      queue_req(make_req(CMD_ADD, -8388608, 0));
      queue_req(make_req(CMD_ADD, 0, 0));
      queue_req(make_req(CMD_ADD, 8388607, 0));
      queue_req(make_req(CMD_ADD, 250, 0));
      queue_req(make_req(CMD_ADD, 12799, 0));
      queue_req(make_req(CMD_QUERY, 0, 0));
      queue_req(make_req(CMD_QUERY, 0, 65536));
      queue_req(make_req(CMD_QUERY, 0, 131071));
      queue_req(make_req(CMD_QUERY, 0, 40000));
      queue_req(make_req(CMD_NONE, 5, 5));
      queue_req(make_req(CMD_CLEAR, 0, 0));
      queue_req(make_req(CMD_QUERY, 0, 65536));
      wait_drained();

      // Random phases over several bin widths, extremes included
      foreach (widths[k]) begin
         write_width(widths[k]);
         queue_req(make_req(CMD_ADD, 8388607, 0));
         queue_req(make_req(CMD_QUERY, 0, 65536));
         for (int n = 0; n < 280; n++) queue_req(random_req(widths[k]));
         if (k == 5) idle_on = 1'b0;
         if (k == 2) begin
            // pause the sender until everything sent so far has come back
            while (pending_reqs.size() > 140) @(posedge clock);
            hold_send = 1'b1;
            while (expected_rsps.size() > 0 || req_push) @(posedge clock);
            hold_send = 1'b0;
         end
         wait_drained();
      end

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
